// File: src/avcap_pkg.sv
package avcap_pkg;

    localparam int unsigned CFG_W      = 3;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 32;
    localparam int unsigned SEEN_W     = 2;
    localparam int unsigned USER_W     = 2;

    localparam logic [CFG_W-1:0] PREFIX_MIN   = 3'd1;
    localparam logic [CFG_W-1:0] PREFIX_MAX   = 3'd4;
    localparam logic [CFG_W-1:0] PREFIX_RESET = 3'd4;

    localparam logic [1:0] SC_LAST_IDX = 2'd3;

    // Annex B start code, emitted in order from index 0
    localparam logic [BYTE_W-1:0] START_CODE [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

    // tuser bit positions on the result side
    localparam int unsigned USER_BYTE_VALID = 0;
    localparam int unsigned USER_TRUNCATED  = 1;

    // Effective prefix size: 0 acts as 1, 5..7 act as 4
    function automatic logic [CFG_W-1:0] prefix_size(input logic [CFG_W-1:0] cfg);
        logic [CFG_W-1:0] s;
        s = cfg;
        if (cfg == '0) begin
            s = PREFIX_MIN;
        end else if (cfg > PREFIX_MAX) begin
            s = PREFIX_MAX;
        end
        return s;
    endfunction

endpackage

// File: src/avc_length_prefix_to_annexb_top.sv
// Channel  | Direction | Signals                          | Carries
// ---------+-----------+----------------------------------+---------------------------------
// s_axis   | in        | tvalid tready tdata[7:0] tlast   | sample byte, tlast = end of sample
// m_axis   | out       | tvalid tready tdata[7:0] tlast   | out byte, tlast = last of sample,
//          |           | tuser[1:0]                       | tuser = {truncated, byte_valid}
// cfg      | in        | i_cfg_valid o_cfg_ready          | length prefix size (3 bits)
//
// A payload byte or an incomplete prefix byte: one request per clock unless the output stalls.
// A completed prefix yields four start code beats from the output register, so the
// input is held off while the start code index counts through.
// Reset (i_rst_n low at a clock edge) clears the parse state and sets prefix size to 4.
// Output stalls back up through the single output register into s_axis_tready; a new
// request is taken in the same cycle the final beat of the previous one leaves.
module avc_length_prefix_to_annexb_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [avcap_pkg::BYTE_W-1:0]   s_axis_tdata,   // [7:0] sample_byte
    input  logic                           s_axis_tlast,   // sample_end

    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [avcap_pkg::BYTE_W-1:0]   m_axis_tdata,   // [7:0] out_byte
    output logic                           m_axis_tlast,   // last_of_sample
    output logic [avcap_pkg::USER_W-1:0]   m_axis_tuser,   // [0] byte_valid, [1] truncated

    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [avcap_pkg::CFG_W-1:0]    i_cfg_data      // length_prefix_bytes
);
    import avcap_pkg::*;

    // configuration
    logic [CFG_W-1:0]  r_cfg;
    logic [CFG_W-1:0]  w_psize;

    // parse state
    logic              r_in_payload, n_in_payload;
    logic [SEEN_W-1:0] r_seen,       n_seen;
    logic [LEN_W-1:0]  r_len,        n_len;

    // output register: either one plain beat or a four-beat start code
    logic              r_ov,   n_ov;
    logic              r_sc,   n_sc;
    logic [1:0]        r_idx,  n_idx;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_bv,   n_bv;
    logic              r_last, n_last;
    logic              r_tr,   n_tr;

    logic              w_accept;
    logic              w_final_beat;
    logic              w_out_take;

    // per-request decode
    logic              w_emit;
    logic              w_emit_sc;
    logic [BYTE_W-1:0] w_byte;
    logic              w_bv;
    logic              w_last;
    logic              w_tr;
    logic [LEN_W-1:0]  w_rem;
    logic [LEN_W-1:0]  w_acc;
    logic [CFG_W-1:0]  w_seen_inc;

    assign o_cfg_ready = 1'b1;
    assign w_psize     = prefix_size(r_cfg);

    assign w_final_beat  = !r_sc || (r_idx == SC_LAST_IDX);
    assign w_out_take    = r_ov && m_axis_tready;
    assign s_axis_tready = !r_ov || (m_axis_tready && w_final_beat);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_rem      = r_len - LEN_W'(1);
    assign w_acc      = (r_seen == '0) ? LEN_W'(s_axis_tdata)
                                       : {r_len[LEN_W-BYTE_W-1:0], s_axis_tdata};
    assign w_seen_inc = CFG_W'(r_seen) + CFG_W'(1);

    // parse one input byte
    always_comb begin
        n_in_payload = r_in_payload;
        n_seen       = r_seen;
        n_len        = r_len;
        w_emit       = 1'b0;
        w_emit_sc    = 1'b0;
        w_byte       = '0;
        w_bv         = 1'b0;
        w_last       = 1'b0;
        w_tr         = 1'b0;

        if (r_in_payload) begin
            n_len        = w_rem;
            n_in_payload = (w_rem != '0);
            w_emit       = 1'b1;
            w_byte       = s_axis_tdata;
            w_bv         = 1'b1;
            w_last       = s_axis_tlast;
            w_tr         = s_axis_tlast && (w_rem != '0);
        end else if (w_seen_inc >= w_psize) begin
            // prefix complete: start code, then payload unless the length is zero
            n_seen       = '0;
            n_len        = w_acc;
            n_in_payload = (w_acc != '0);
            w_emit       = 1'b1;
            w_emit_sc    = 1'b1;
            w_bv         = 1'b1;
            w_last       = s_axis_tlast;
            w_tr         = s_axis_tlast && (w_acc != '0);
        end else begin
            n_seen = w_seen_inc[SEEN_W-1:0];
            n_len  = w_acc;
            if (s_axis_tlast) begin
                // sample ended inside the prefix: bare marker
                w_emit = 1'b1;
                w_last = 1'b1;
                w_tr   = 1'b1;
            end
        end

        if (s_axis_tlast) begin
            n_in_payload = 1'b0;
            n_seen       = '0;
            n_len        = '0;
        end
    end

    // output register next value
    always_comb begin
        n_ov   = r_ov;
        n_sc   = r_sc;
        n_idx  = r_idx;
        n_byte = r_byte;
        n_bv   = r_bv;
        n_last = r_last;
        n_tr   = r_tr;

        if (w_out_take) begin
            if (w_final_beat) begin
                n_ov = 1'b0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end

        if (w_accept && w_emit) begin
            n_ov   = 1'b1;
            n_sc   = w_emit_sc;
            n_idx  = '0;
            n_byte = w_byte;
            n_bv   = w_bv;
            n_last = w_last;
            n_tr   = w_tr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg        <= PREFIX_RESET;
            r_in_payload <= 1'b0;
            r_seen       <= '0;
            r_len        <= '0;
            r_ov         <= 1'b0;
            r_sc         <= 1'b0;
            r_idx        <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
            if (w_accept) begin
                r_in_payload <= n_in_payload;
                r_seen       <= n_seen;
                r_len        <= n_len;
            end
            r_ov  <= n_ov;
            r_sc  <= n_sc;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_bv   <= n_bv;
        r_last <= n_last;
        r_tr   <= n_tr;
    end

    // start code beats: only the last one carries end-of-sample flags
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_sc ? START_CODE[r_idx] : r_byte;
    assign m_axis_tlast  = r_sc ? (r_last && r_idx == SC_LAST_IDX) : r_last;
    assign m_axis_tuser[USER_BYTE_VALID] = r_sc ? 1'b1 : r_bv;
    assign m_axis_tuser[USER_TRUNCATED]  = r_sc ? (r_tr && r_idx == SC_LAST_IDX) : r_tr;

    // ---------------- assertions ----------------
    a_sc_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_sc && !w_final_beat && m_axis_tready) |=> (r_idx == $past(r_idx) + 2'd1))
        else $error("start code index did not advance on a taken beat");

    a_trunc_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[USER_TRUNCATED]) |-> m_axis_tlast)
        else $error("truncated flag outside the last result of a sample");

    a_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[USER_BYTE_VALID]) |->
            (m_axis_tlast && m_axis_tuser[USER_TRUNCATED] && m_axis_tdata == '0))
        else $error("bare marker malformed");

    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_len != '0 && r_seen == '0))
        else $error("payload state with zero count or partial prefix");

    a_no_accept_mid_sc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_sc && r_idx != SC_LAST_IDX) |-> !s_axis_tready)
        else $error("input taken while start code beats remain");

endmodule

// File: dv/tb_avc_length_prefix_to_annexb_top.sv
`timescale 1ns / 1ps

module tb_avc_length_prefix_to_annexb_top;

    import avcap_pkg::*;

    // Idle rates in percent of cycles
    localparam int unsigned IDLE_NONE  = 0;
    localparam int unsigned IDLE_HEAVY = 79;
    localparam int unsigned IDLE_MIXED = 22;

    // Quiet cycles after the last expected beat: a prefix byte that completes no
    // prefix leaves nothing to wait on, so give the pipe time to settle
    localparam int unsigned SETTLE_CYCLES = 16;
    // Receiver hold-off long enough to back the block up into s_axis_tready
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned MAX_REPORTS = 40;

    // One Annex B output beat as the checker sees it
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              valid;
        logic              last;
        logic              trunc;
    } t_annexb_beat;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [BYTE_W-1:0]    s_axis_tdata  = '0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]    m_axis_tdata;
    logic                 m_axis_tlast;
    logic [USER_W-1:0]    m_axis_tuser;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_W-1:0]     i_cfg_data    = '0;

    // Predicted parser state, mirrors the block's
    logic [CFG_W-1:0]     pfx_cfg = PREFIX_RESET;
    logic                 in_nal  = 1'b0;
    logic [SEEN_W-1:0]    pfx_seen = '0;
    logic [LEN_W-1:0]     nal_len = '0;

    t_annexb_beat         pending_beats[$];
    logic [BYTE_W-1:0]    sample_q[$];

    int unsigned          err_count      = 0;
    int unsigned          items_sent     = 0;
    int unsigned          src_idle_pct   = IDLE_NONE;
    int unsigned          sink_stall_pct = IDLE_NONE;
    int unsigned          sink_hold      = 0;
    // Hold-off requests from the stimulus, and how many the receiver has taken up
    int unsigned          hold_reqs      = 0;
    int unsigned          hold_seen      = 0;

    avc_length_prefix_to_annexb_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] sample_byte
        .s_axis_tlast  (s_axis_tlast),   // sample_end
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] out_byte
        .m_axis_tlast  (m_axis_tlast),   // last_of_sample
        .m_axis_tuser  (m_axis_tuser),   // [0] byte_valid, [1] truncated
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Register value to prefix length: 0 reads as 1, anything above 4 as 4
    function automatic int unsigned eff_prefix_len(input logic [CFG_W-1:0] cfg);
        if (cfg == 3'd0) begin
            return 1;
        end
        if (cfg > 3'd4) begin
            return 4;
        end
        return 32'(cfg);
    endfunction

    // Advance the parser by one accepted sample byte and queue the beats it yields
    task automatic convert_sample_byte(input logic [BYTE_W-1:0] b, input logic eos);
        logic [LEN_W-1:0] len;
        int unsigned      seen_next;
        if (in_nal) begin
            // Payload byte: passes through, count down what is left
            nal_len = nal_len - LEN_W'(1);
            if (nal_len == 0) begin
                in_nal = 1'b0;
            end
            pending_beats.insert(pending_beats.size(),
                t_annexb_beat'{b, 1'b1, eos, eos && (nal_len != 0)});
        end else begin
            // Prefix byte: shift it in big-endian
            len = (pfx_seen == 0) ? {24'd0, b} : {nal_len[LEN_W-9:0], b};
            seen_next = 32'(pfx_seen) + 1;
            if (seen_next >= eff_prefix_len(pfx_cfg)) begin
                // Prefix complete: start code, last beat carries end-of-sample
                pfx_seen = '0;
                for (int i = 0; i < 4; i++) begin
                    pending_beats.insert(pending_beats.size(),
                        t_annexb_beat'{START_CODE[i], 1'b1,
                        eos && (i == 3), eos && (i == 3) && (len != 0)});
                end
                in_nal  = (len != 0);
                nal_len = len;
            end else begin
                pfx_seen = seen_next[SEEN_W-1:0];
                nal_len  = len;
                if (eos) begin
                    // Sample cut inside a prefix: bare marker only
                    pending_beats.insert(pending_beats.size(),
                        t_annexb_beat'{8'h00, 1'b0, 1'b1, 1'b1});
                end
            end
        end
        if (eos) begin
            in_nal   = 1'b0;
            pfx_seen = '0;
            nal_len  = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one sample byte; valid stays high across back-to-back requests
    task automatic send_sample_byte(input logic [BYTE_W-1:0] b, input logic eos);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        convert_sample_byte(b, eos);
    endtask

    // Stop offering, let every queued beat drain, then allow the pipe to settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write only once the block has gone quiet
    task automatic write_prefix_size(input logic [CFG_W-1:0] v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pfx_cfg = v;
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen     <= hold_reqs;
            m_axis_tready <= 1'b0;
            sink_hold     <= HOLD_OFF_CYCLES - 1;
        end else if (sink_hold != 0) begin
            m_axis_tready <= 1'b0;
            sink_hold     <= sink_hold - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Checker: every output beat against the oldest prediction
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            err_count++;
            if (err_count <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_annexb_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_beats.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected beat, expected none, got data %0h tuser %0b",
                             $time, m_axis_tdata, m_axis_tuser);
                end
            end else begin
                want = pending_beats.pop_front();
                check_field("out_byte", 32'(want.data), 32'(m_axis_tdata));
                check_field("byte_valid", 32'(want.valid),
                            32'(m_axis_tuser[USER_BYTE_VALID]));
                check_field("last_of_sample", 32'(want.last), 32'(m_axis_tlast));
                check_field("truncated", 32'(want.trunc),
                            32'(m_axis_tuser[USER_TRUNCATED]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // One NAL unit at the current prefix size: big-endian length, random payload
    task automatic build_nal(input int unsigned len);
        int unsigned n;
        n = eff_prefix_len(pfx_cfg);
        for (int i = n - 1; i >= 0; i--) begin
            sample_q.insert(sample_q.size(), BYTE_W'(len >> (8 * i)));
        end
        repeat (len) sample_q.insert(sample_q.size(), BYTE_W'($urandom_range(255)));
    endtask

    // Mostly well-formed samples, some cut short, some pure noise
    task automatic send_random_sample();
        int unsigned pick;
        int unsigned cut;
        sample_q.delete();
        pick = $urandom_range(99);
        if (pick < 10) begin
            // noise: random bytes read as prefixes, often huge lengths
            repeat ($urandom_range(12, 1)) begin
                sample_q.insert(sample_q.size(), BYTE_W'($urandom_range(255)));
            end
        end else begin
            repeat ($urandom_range(3, 1)) begin
                build_nal(($urandom_range(3) == 0) ? $urandom_range(20) : $urandom_range(6));
            end
            if (pick < 25) begin
                // truncated somewhere inside the sample
                cut = $urandom_range(sample_q.size() - 1);
                while (sample_q.size() > cut + 1) void'(sample_q.pop_back());
            end
        end
        foreach (sample_q[i]) begin
            send_sample_byte(sample_q[i], i == sample_q.size() - 1);
        end
    endtask

    task automatic run_random_phase(input logic [CFG_W-1:0] size_cfg, input int unsigned src_pct,
                                    input int unsigned sink_pct, input int unsigned n_items);
        int unsigned first;
        write_prefix_size(size_cfg);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        first = items_sent;
        while (items_sent - first < n_items) send_random_sample();
        wait_drained();
    endtask

    // Reset size is 4: one NAL of two bytes, sample ends on the last payload byte
    task automatic test_reset_prefix_size();
        send_sample_byte(8'h00, 1'b0);
        send_sample_byte(8'h00, 1'b0);
        send_sample_byte(8'h00, 1'b0);
        send_sample_byte(8'h02, 1'b0);
        send_sample_byte(8'hAA, 1'b0);
        send_sample_byte(8'h55, 1'b1);
    endtask

    // One-byte prefix: empty NAL, then length 255 read unsigned, cut short
    task automatic test_one_byte_prefix();
        write_prefix_size(3'd1);
        send_sample_byte(8'h00, 1'b0);
        send_sample_byte(8'hFF, 1'b0);
        send_sample_byte(8'h80, 1'b0);
        send_sample_byte(8'h7F, 1'b1);
    endtask

    // Sample ends mid-prefix (bare marker), then right at a nonzero prefix
    task automatic test_truncation();
        write_prefix_size(3'd3);
        send_sample_byte(8'h00, 1'b0);
        send_sample_byte(8'h01, 1'b1);
        send_sample_byte(8'h00, 1'b0);
        send_sample_byte(8'h00, 1'b0);
        send_sample_byte(8'h05, 1'b1);
    endtask

    // Register 0 acts as 1; 7 acts as 4, with a zero length closing the sample
    task automatic test_out_of_range_size();
        write_prefix_size(3'd0);
        send_sample_byte(8'h01, 1'b0);
        send_sample_byte(8'h5A, 1'b1);
        write_prefix_size(3'd7);
        send_sample_byte(8'h00, 1'b0);
        send_sample_byte(8'h00, 1'b0);
        send_sample_byte(8'h00, 1'b0);
        send_sample_byte(8'h00, 1'b1);
    endtask

    // Size drops from 4 to 2 with two prefix bytes gathered: next byte completes it
    task automatic test_size_change_mid_prefix();
        write_prefix_size(3'd4);
        send_sample_byte(8'h00, 1'b0);
        send_sample_byte(8'h00, 1'b0);
        write_prefix_size(3'd2);
        send_sample_byte(8'h03, 1'b0);
        send_sample_byte(8'h11, 1'b1);
    endtask

    // Eight phases over all register values and four idling mixes
    task automatic test_random_traffic();
        run_random_phase(3'd1, IDLE_NONE,  IDLE_NONE,  12);
        run_random_phase(3'd4, IDLE_HEAVY, IDLE_NONE,  12);
        run_random_phase(3'd2, IDLE_NONE,  IDLE_HEAVY, 12);
        run_random_phase(3'd3, IDLE_MIXED, IDLE_MIXED, 12);
        run_random_phase(3'd0, IDLE_NONE,  IDLE_NONE,  12);
        run_random_phase(3'd5, IDLE_HEAVY, IDLE_NONE,  12);
        run_random_phase(3'd7, IDLE_NONE,  IDLE_HEAVY, 12);
        run_random_phase(3'd6, IDLE_MIXED, IDLE_MIXED, 12);
    endtask

    // Receiver holds off while the sender keeps pushing requests at full rate;
    // one-byte prefixes give start code bursts that back the block up fast
    task automatic test_output_backpressure();
        int unsigned first;
        write_prefix_size(3'd1);
        src_idle_pct   = IDLE_NONE;
        sink_stall_pct = IDLE_NONE;
        hold_reqs++;
        first = items_sent;
        while (items_sent - first < 20) send_random_sample();
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_prefix_size();
        test_one_byte_prefix();
        test_truncation();
        test_out_of_range_size();
        test_size_change_mid_prefix();
        test_random_traffic();
        test_output_backpressure();

        wait_drained();
        if (err_count == 0 && pending_beats.size() == 0) begin
            $display("PASS avc_length_prefix_to_annexb_top");
        end else begin
            $display("FAIL avc_length_prefix_to_annexb_top");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2ms;
        $display("FAIL avc_length_prefix_to_annexb_top");
        $finish;
    end

endmodule
